// ----- hdl/wse_pkg.sv -----
package wse_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int SPEED_W     = 24;
    localparam int Q_DEPTH     = 2;

    localparam logic [7:0] W_KEEP = 8'd179;  // 0.7 in Q0.8
    localparam logic [6:0] W_OLD  = 7'd77;   // 0.3 in Q0.8
    localparam logic [8:0] W_ONE  = 9'd256;

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_POLL  = 2'd1,
        OP_STOP  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_INTERVAL  = 3'd1,
        CFG_MIN_PULSE = 3'd2,
        CFG_WEIGHT    = 3'd3,
        CFG_SCALE     = 3'd4,
        CFG_THRESHOLD = 3'd5
    } t_cfg_addr;

    // command kinds handed from the front end to the arithmetic back end
    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_WIN   = 2'd1,
        K_STOP  = 2'd2,
        K_QUERY = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [COUNT_WIDTH-1:0] raw;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        debounce_us;
        logic [15:0]        interval_ms;
        logic [7:0]         min_pulses;
        logic [8:0]         ema_weight;
        logic [15:0]        speed_scale;
        logic [SPEED_W-1:0] stable_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        debounce_us:      16'd1000,
        interval_ms:      16'd100,
        min_pulses:       8'd2,
        ema_weight:       9'd77,
        speed_scale:      16'd256,
        stable_threshold: 24'd1280
    };

    function automatic logic [SPEED_W-1:0] sat24(input logic [47:0] v);
        logic [SPEED_W-1:0] r;
        r = (|v[47:SPEED_W]) ? SPEED_MAX : v[SPEED_W-1:0];
        return r;
    endfunction

endpackage

// ----- hdl/wheel_speed_estimator.sv -----
// Wheel speed estimator: debounced pulse counter with a moving-average speed filter.
// Slave stream: one event per transaction, tuser = opcode (edge, poll, stop,
// stability query), tdata = microsecond and millisecond timestamps.
// Master stream: exactly one result transaction per event, in order; tdata
// carries current speed, display speed and the stability flag, tuser flags a
// poll that closed a measurement window.
// Edge and window timing is resolved by the front end as the event is taken;
// a two-entry command queue feeds the arithmetic back end, which owns one
// registered multiply step per cycle unless the output stalls. Edge, stop,
// query and non-closing poll events pass through the queue entry and the output
// register and sustain one per cycle while the back end is idle and not stalled.
// A closing poll with enough pulses passes moving average product, blend, speed
// scale, display blend and output; one below the pulse minimum decays filter and
// display, then scales and outputs. Config writes are registered via the write port.
// Synchronous reset clears counts, timestamps, speeds and the queue, and loads
// the default configuration. A stalled master output holds its transaction;
// the queue then fills and tready drops.
module wheel_speed_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] time_us, [63:32] time_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [23:0] speed_now, [47:24] speed_display,
                                        // [48] is_stable, [55:49] zero
    output logic        m_axis_tuser,   // [0] window_done
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata
);
    import wse_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, q_full, q_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_DEBOUNCE:  r_cfg.debounce_us      <= i_cfg_wdata[15:0];
                CFG_INTERVAL:  r_cfg.interval_ms      <= i_cfg_wdata[15:0];
                CFG_MIN_PULSE: r_cfg.min_pulses       <= i_cfg_wdata[7:0];
                CFG_WEIGHT:    r_cfg.ema_weight       <= i_cfg_wdata[8:0];
                CFG_SCALE:     r_cfg.speed_scale      <= i_cfg_wdata[15:0];
                CFG_THRESHOLD: r_cfg.stable_threshold <= i_cfg_wdata[SPEED_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    wse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg         (r_cfg),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    wse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    wse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- hdl/wse_front.sv -----
module wse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,
    input  logic [1:0]    s_axis_tuser,
    input  wse_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output wse_pkg::t_cmd o_cmd
);
    import wse_pkg::*;

    logic [COUNT_WIDTH-1:0] r_edge_count, n_edge_count;
    logic [31:0]            r_last_edge_us, n_last_edge_us;
    logic [31:0]            r_last_win_ms, n_last_win_ms;

    logic [31:0] time_us, time_ms, el_us, el_ms;
    t_op         op;
    logic        accept;

    assign time_us       = s_axis_tdata[31:0];
    assign time_ms       = s_axis_tdata[63:32];
    assign op            = t_op'(s_axis_tuser);
    assign s_axis_tready = !i_q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push        = accept;

    // elapsed times wrap modulo 2^32
    assign el_us = time_us - r_last_edge_us;
    assign el_ms = time_ms - r_last_win_ms;

    always_comb begin
        n_edge_count   = r_edge_count;
        n_last_edge_us = r_last_edge_us;
        n_last_win_ms  = r_last_win_ms;
        o_cmd.kind     = K_NONE;
        o_cmd.raw      = r_edge_count;
        unique case (op)
            OP_EDGE: begin
                if (el_us > 32'(i_cfg.debounce_us)) begin
                    if (r_edge_count != '1) begin
                        n_edge_count = r_edge_count + 1'b1;
                    end
                    n_last_edge_us = time_us;
                end
            end
            OP_POLL: begin
                if (el_ms >= 32'(i_cfg.interval_ms)) begin
                    o_cmd.kind    = K_WIN;
                    n_edge_count  = '0;
                    n_last_win_ms = time_ms;
                end
            end
            OP_STOP:  o_cmd.kind = K_STOP;
            OP_QUERY: o_cmd.kind = K_QUERY;
            default:  o_cmd.kind = K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count   <= '0;
            r_last_edge_us <= '0;
            r_last_win_ms  <= '0;
        end else if (accept) begin
            r_edge_count   <= n_edge_count;
            r_last_edge_us <= n_last_edge_us;
            r_last_win_ms  <= n_last_win_ms;
        end
    end

endmodule

// ----- hdl/wse_queue.sv -----
module wse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wse_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output wse_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import wse_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/wse_back.sv -----
module wse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wse_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  wse_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [55:0]   m_axis_tdata,
    output logic          m_axis_tuser
);
    import wse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EMA   = 4'b0010,
        S_SCALE = 4'b0100,
        S_DISP  = 4'b1000
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [SPEED_W-1:0] r_filt, n_filt;
    logic [SPEED_W-1:0] r_cur, n_cur;
    logic [SPEED_W-1:0] r_disp, n_disp;
    logic [SPEED_W-1:0] r_qry, n_qry;
    logic [32:0]        r_prod, n_prod;
    logic               r_full, n_full;

    logic               r_out_valid, n_out_valid;
    logic [SPEED_W-1:0] r_out_now, n_out_now;
    logic [SPEED_W-1:0] r_out_disp, n_out_disp;
    logic               r_out_stable, n_out_stable;
    logic               r_out_done, n_out_done;

    logic               out_free, out_load;
    logic [8:0]         w, w_old;
    logic [SPEED_W-1:0] raw_q, spd, disp_mix, diff;
    logic               full_upd;

    assign out_free = !r_out_valid || m_axis_tready;

    // weight of the new count is capped at one
    assign w     = (i_cfg.ema_weight > W_ONE) ? W_ONE : i_cfg.ema_weight;
    assign w_old = W_ONE - w;

    assign raw_q    = sat24(48'(i_cmd.raw) << FRAC_BITS);
    assign full_upd = 32'(i_cmd.raw) >= 32'(i_cfg.min_pulses);
    assign spd      = sat24(48'((40'(r_filt) * 40'(i_cfg.speed_scale)) >> 8));
    assign disp_mix = sat24(48'((34'(W_KEEP) * 34'(r_cur) + 34'(W_OLD) * 34'(r_disp)) >> 8));
    assign diff     = (r_cur >= r_qry) ? (r_cur - r_qry) : (r_qry - r_cur);

    always_comb begin
        n_state      = r_state;
        n_filt       = r_filt;
        n_cur        = r_cur;
        n_disp       = r_disp;
        n_qry        = r_qry;
        n_prod       = r_prod;
        n_full       = r_full;
        n_out_now    = r_out_now;
        n_out_disp   = r_out_disp;
        n_out_stable = r_out_stable;
        n_out_done   = r_out_done;
        out_load     = 1'b0;
        o_pop        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == K_WIN) begin
                        o_pop   = 1'b1;
                        n_full  = full_upd;
                        n_state = full_upd ? S_EMA : S_SCALE;
                        if (full_upd) begin
                            n_prod = 33'(raw_q) * 33'(w);
                        end else begin
                            n_filt = r_filt >> 1;
                            n_disp = SPEED_W'((32'(W_KEEP) * 32'(r_disp)) >> 8);
                        end
                    end else if (out_free) begin
                        o_pop        = 1'b1;
                        out_load     = 1'b1;
                        n_out_now    = r_cur;
                        n_out_disp   = r_disp;
                        n_out_stable = 1'b0;
                        n_out_done   = 1'b0;
                        case (i_cmd.kind)
                            K_STOP: begin
                                n_cur      = '0;
                                n_disp     = '0;
                                n_out_now  = '0;
                                n_out_disp = '0;
                            end
                            K_QUERY: begin
                                n_qry        = r_cur;
                                n_out_stable = diff < i_cfg.stable_threshold;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_EMA: begin
                n_filt  = sat24(48'((34'(r_prod) + 34'(r_filt) * 34'(w_old)) >> 8));
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_cur = spd;
                if (r_full) begin
                    n_state = S_DISP;
                end else if (out_free) begin
                    out_load     = 1'b1;
                    n_out_now    = spd;
                    n_out_disp   = r_disp;
                    n_out_stable = 1'b0;
                    n_out_done   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DISP: begin
                if (out_free) begin
                    n_disp       = disp_mix;
                    out_load     = 1'b1;
                    n_out_now    = r_cur;
                    n_out_disp   = disp_mix;
                    n_out_stable = 1'b0;
                    n_out_done   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filt      <= '0;
            r_cur       <= '0;
            r_disp      <= '0;
            r_qry       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filt      <= n_filt;
            r_cur       <= n_cur;
            r_disp      <= n_disp;
            r_qry       <= n_qry;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod       <= n_prod;
        r_out_now    <= n_out_now;
        r_out_disp   <= n_out_disp;
        r_out_stable <= n_out_stable;
        r_out_done   <= n_out_done;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_stable, r_out_disp, r_out_now};
    assign m_axis_tuser  = r_out_done;

endmodule

// ----- hdl/wse_checker.sv -----
module wse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // only a query sets the stability flag, never a window close
    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[48])
        else $error("window close and stability flag together");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
        else $error("nonzero padding in result");

endmodule

bind wheel_speed_estimator wse_checker u_wse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
